// ----- rtl/hrtm_pkg.sv -----
// hrtm_pkg: widths, register codes, interface structs, popcount and mask helpers
// for the hamming ratio test matcher. No dependencies.
package hrtm_pkg;

   localparam int WORD_WIDTH      = 64;
   localparam int NUM_WORDS       = 4;
   localparam int DESC_WIDTH      = WORD_WIDTH * NUM_WORDS;
   localparam int DIST_WIDTH      = 9;
   localparam int WCOUNT_WIDTH    = 7;
   localparam int INDEX_WIDTH     = 12;
   localparam int CFG_WIDTH       = 9;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int SCALE_SHIFT     = 8;
   localparam int PROD_WIDTH      = 2 * CFG_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_DISTANCE = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RATIO_Q8     = 8'd1;

   localparam logic [CFG_WIDTH-1:0] MAX_DISTANCE_RESET = 9'd50;
   localparam logic [CFG_WIDTH-1:0] RATIO_Q8_RESET     = 9'd230;

   localparam int MAX_FEATURES_DEFAULT    = 4096;
   localparam int DESCRIPTOR_BITS_DEFAULT = 256;

   // per-candidate beat after the popcount stage
   typedef struct packed {
      logic [NUM_WORDS-1:0][WCOUNT_WIDTH-1:0] word_count;
      logic [INDEX_WIDTH-1:0]                 index;
      logic                                   in_range;
      logic                                   last;
   } cand_type;

   // search state captured at the end of a query
   typedef struct packed {
      logic                   best_valid;
      logic [DIST_WIDTH-1:0]  best_dist;
      logic                   second_valid;
      logic [DIST_WIDTH-1:0]  second_dist;
      logic [INDEX_WIDTH-1:0] best_cand;
   } snap_type;

   function automatic logic [3:0] pop8(logic [7:0] x);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + 4'(x[i]);
      end
      return n;
   endfunction

   function automatic logic [WCOUNT_WIDTH-1:0] pop64(logic [WORD_WIDTH-1:0] x);
      logic [WCOUNT_WIDTH-1:0] n;
      n = '0;
      for (int i = 0; i < WORD_WIDTH / 8; i++) begin
         n = n + WCOUNT_WIDTH'(pop8(x[8*i +: 8]));
      end
      return n;
   endfunction

   function automatic logic [DESC_WIDTH-1:0] desc_mask(int bits);
      logic [DESC_WIDTH-1:0] m;
      for (int i = 0; i < DESC_WIDTH; i++) begin
         m[i] = (i < bits);
      end
      return m;
   endfunction

endpackage

// ----- rtl/hrtm_distance.sv -----
// hrtm_distance: input register (masked xor) and per-word popcount register.
// Depends on hrtm_pkg.
module hrtm_distance
   import hrtm_pkg::*;
#(
   parameter int MAX_FEATURES    = MAX_FEATURES_DEFAULT,
   parameter int DESCRIPTOR_BITS = DESCRIPTOR_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [DESC_WIDTH-1:0]  in_query,
   input  logic [DESC_WIDTH-1:0]  in_cand,
   input  logic [INDEX_WIDTH-1:0] in_index,
   input  logic                   in_last,
   output logic                   out_valid,
   input  logic                   out_ready,
   output cand_type               out_cand
);

   localparam logic [DESC_WIDTH-1:0] MASK = desc_mask(DESCRIPTOR_BITS);

   logic                   a_valid_ff, a_valid_in;
   logic [DESC_WIDTH-1:0]  a_diff_ff, a_diff_in;
   logic [INDEX_WIDTH-1:0] a_index_ff, a_index_in;
   logic                   a_in_range_ff, a_in_range_in;
   logic                   a_last_ff, a_last_in;
   logic                   a_ready;

   logic                   b_valid_ff, b_valid_in;
   cand_type               b_cand_ff, b_cand_in;
   logic                   b_ready;
   cand_type               b_next;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_comb begin
      a_valid_in    = a_ready ? in_valid : a_valid_ff;
      a_diff_in     = a_diff_ff;
      a_index_in    = a_index_ff;
      a_in_range_in = a_in_range_ff;
      a_last_in     = a_last_ff;
      if (in_valid && a_ready) begin
         a_diff_in     = (in_query ^ in_cand) & MASK;
         a_index_in    = in_index;
         a_in_range_in = (32'(in_index) < MAX_FEATURES);
         a_last_in     = in_last;
      end
   end

   always_comb begin
      for (int w = 0; w < NUM_WORDS; w++) begin
         b_next.word_count[w] = pop64(a_diff_ff[w*WORD_WIDTH +: WORD_WIDTH]);
      end
      b_next.index    = a_index_ff;
      b_next.in_range = a_in_range_ff;
      b_next.last     = a_last_ff;
   end

   always_comb begin
      b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
      b_cand_in  = (a_valid_ff && b_ready) ? b_next : b_cand_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_diff_ff     <= a_diff_in;
      a_index_ff    <= a_index_in;
      a_in_range_ff <= a_in_range_in;
      a_last_ff     <= a_last_in;
      b_cand_ff     <= b_cand_in;
   end

   assign out_valid = b_valid_ff;
   assign out_cand  = b_cand_ff;

endmodule

// ----- rtl/hrtm_tracker.sv -----
// hrtm_tracker: sums word counts, keeps best and second-best distance,
// and captures the search state on the last candidate. Depends on hrtm_pkg.
module hrtm_tracker
   import hrtm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     cand_valid,
   output logic     cand_ready,
   input  cand_type cand,
   output logic     snap_valid,
   input  logic     snap_ready,
   output snap_type snap
);

   logic                   best_valid_ff, best_valid_in;
   logic [DIST_WIDTH-1:0]  best_dist_ff, best_dist_in;
   logic                   second_valid_ff, second_valid_in;
   logic [DIST_WIDTH-1:0]  second_dist_ff, second_dist_in;
   logic [INDEX_WIDTH-1:0] best_cand_ff, best_cand_in;
   logic                   snap_valid_ff, snap_valid_in;
   snap_type               snap_ff, snap_in;

   logic [DIST_WIDTH-1:0]  cand_dist;
   logic                   take;
   snap_type               upd;

   // a non-last beat never needs the result side
   assign cand_ready = !cand.last || !snap_valid_ff || snap_ready;
   assign take       = cand_valid && cand_ready;

   always_comb begin
      cand_dist = '0;
      for (int w = 0; w < NUM_WORDS; w++) begin
         cand_dist = cand_dist + DIST_WIDTH'(cand.word_count[w]);
      end
   end

   always_comb begin
      upd.best_valid   = best_valid_ff;
      upd.best_dist    = best_dist_ff;
      upd.second_valid = second_valid_ff;
      upd.second_dist  = second_dist_ff;
      upd.best_cand    = best_cand_ff;
      if (cand.in_range) begin
         if (!best_valid_ff || cand_dist < best_dist_ff) begin
            upd.second_valid = best_valid_ff;
            upd.second_dist  = best_dist_ff;
            upd.best_valid   = 1'b1;
            upd.best_dist    = cand_dist;
            upd.best_cand    = cand.index;
         end else if (!second_valid_ff || cand_dist < second_dist_ff) begin
            upd.second_valid = 1'b1;
            upd.second_dist  = cand_dist;
         end
      end
   end

   always_comb begin
      best_valid_in   = best_valid_ff;
      best_dist_in    = best_dist_ff;
      second_valid_in = second_valid_ff;
      second_dist_in  = second_dist_ff;
      best_cand_in    = best_cand_ff;
      snap_in         = snap_ff;
      if (take) begin
         if (cand.last) begin
            // query ends: hand the state on and start afresh
            snap_in         = upd;
            best_valid_in   = 1'b0;
            second_valid_in = 1'b0;
         end else begin
            best_valid_in   = upd.best_valid;
            best_dist_in    = upd.best_dist;
            second_valid_in = upd.second_valid;
            second_dist_in  = upd.second_dist;
            best_cand_in    = upd.best_cand;
         end
      end
      snap_valid_in = (snap_valid_ff && !snap_ready) || (take && cand.last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_valid_ff   <= 1'b0;
         second_valid_ff <= 1'b0;
         snap_valid_ff   <= 1'b0;
      end else begin
         best_valid_ff   <= best_valid_in;
         second_valid_ff <= second_valid_in;
         snap_valid_ff   <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_dist_ff   <= best_dist_in;
      second_dist_ff <= second_dist_in;
      best_cand_ff   <= best_cand_in;
      snap_ff        <= snap_in;
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

// ----- rtl/hrtm_decide.sv -----
// hrtm_decide: absolute threshold and ratio test, result register.
// Depends on hrtm_pkg.
module hrtm_decide
   import hrtm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   snap_valid,
   output logic                   snap_ready,
   input  snap_type               snap,
   input  logic [CFG_WIDTH-1:0]   max_distance,
   input  logic [CFG_WIDTH-1:0]   ratio_q8,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_match_found,
   output logic [INDEX_WIDTH-1:0] rsp_match_index,
   output logic [DIST_WIDTH-1:0]  rsp_match_distance
);

   logic                   valid_ff, valid_in;
   logic                   found_ff, found_in;
   logic [INDEX_WIDTH-1:0] index_ff, index_in;
   logic [DIST_WIDTH-1:0]  dist_ff, dist_in;

   logic [PROD_WIDTH-1:0]  scaled_best;
   logic [PROD_WIDTH-1:0]  scaled_second;
   logic                   found;
   logic                   load;

   assign snap_ready = !valid_ff || rsp_ready;
   assign load       = snap_valid && snap_ready;

   assign scaled_best   = PROD_WIDTH'(snap.best_dist) << SCALE_SHIFT;
   assign scaled_second = PROD_WIDTH'(snap.second_dist) * PROD_WIDTH'(ratio_q8);

   // missing second neighbour counts as infinitely far
   assign found = snap.best_valid && (snap.best_dist <= max_distance) &&
                  (ratio_q8 != '0) &&
                  (!snap.second_valid || (scaled_best < scaled_second));

   always_comb begin
      valid_in = snap_ready ? snap_valid : valid_ff;
      found_in = found_ff;
      index_in = index_ff;
      dist_in  = dist_ff;
      if (load) begin
         found_in = found;
         index_in = found ? snap.best_cand : '0;
         dist_in  = snap.best_valid ? snap.best_dist : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      index_ff <= index_in;
      dist_ff  <= dist_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_match_found    = found_ff;
   assign rsp_match_index    = index_ff;
   assign rsp_match_distance = dist_ff;

endmodule

// ----- rtl/hamming_ratio_test_matcher.sv -----
// hamming_ratio_test_matcher: top level, configuration registers and pipeline.
// Depends on hrtm_pkg, hrtm_distance, hrtm_tracker, hrtm_decide.
//
// Usage
//   req_*  : one candidate descriptor per beat, with the query descriptor,
//            the candidate index and a last flag closing the query.
//   rsp_*  : one result beat per query, produced by the candidate marked last.
//   csr_*  : register writes, index 0 max_distance, index 1 ratio_q8; always
//            ready, other indexes are ignored. Write only while idle.
// Timing
//   one candidate per cycle sustained while no last candidate waits for the
//   result register. A last candidate passes the xor register, popcount
//   register, search state update and result register, in that order.
// Reset
//   synchronous; empties the pipeline, clears the search state and loads
//   max_distance 50 and ratio_q8 230.
// Back-pressure
//   candidates that are not last keep flowing while a result waits; a last
//   candidate waits in the pipe until the result register is free, and
//   req_ready drops once the stages behind it are full.
module hamming_ratio_test_matcher
   import hrtm_pkg::*;
#(
   parameter int MAX_FEATURES    = MAX_FEATURES_DEFAULT,
   parameter int DESCRIPTOR_BITS = DESCRIPTOR_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [WORD_WIDTH-1:0]      req_query_word0,
   input  logic [WORD_WIDTH-1:0]      req_query_word1,
   input  logic [WORD_WIDTH-1:0]      req_query_word2,
   input  logic [WORD_WIDTH-1:0]      req_query_word3,
   input  logic [WORD_WIDTH-1:0]      req_cand_word0,
   input  logic [WORD_WIDTH-1:0]      req_cand_word1,
   input  logic [WORD_WIDTH-1:0]      req_cand_word2,
   input  logic [WORD_WIDTH-1:0]      req_cand_word3,
   input  logic [INDEX_WIDTH-1:0]     req_cand_index,
   input  logic                       req_last_cand,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_match_found,
   output logic [INDEX_WIDTH-1:0]     rsp_match_index,
   output logic [DIST_WIDTH-1:0]      rsp_match_distance,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_data
);

   logic [CFG_WIDTH-1:0] max_distance_ff, max_distance_in;
   logic [CFG_WIDTH-1:0] ratio_q8_ff, ratio_q8_in;

   logic     cand_valid;
   logic     cand_ready;
   cand_type cand;
   logic     snap_valid;
   logic     snap_ready;
   snap_type snap;

   assign csr_ready = 1'b1;

   always_comb begin
      max_distance_in = max_distance_ff;
      ratio_q8_in     = ratio_q8_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_DISTANCE: max_distance_in = csr_data;
            CSR_RATIO_Q8:     ratio_q8_in     = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_distance_ff <= MAX_DISTANCE_RESET;
         ratio_q8_ff     <= RATIO_Q8_RESET;
      end else begin
         max_distance_ff <= max_distance_in;
         ratio_q8_ff     <= ratio_q8_in;
      end
   end

   hrtm_distance #(
      .MAX_FEATURES    (MAX_FEATURES),
      .DESCRIPTOR_BITS (DESCRIPTOR_BITS)
   ) u_distance (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_query  ({req_query_word3, req_query_word2, req_query_word1, req_query_word0}),
      .in_cand   ({req_cand_word3, req_cand_word2, req_cand_word1, req_cand_word0}),
      .in_index  (req_cand_index),
      .in_last   (req_last_cand),
      .out_valid (cand_valid),
      .out_ready (cand_ready),
      .out_cand  (cand)
   );

   hrtm_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .cand_valid (cand_valid),
      .cand_ready (cand_ready),
      .cand       (cand),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap)
   );

   hrtm_decide u_decide (
      .clock              (clock),
      .reset              (reset),
      .snap_valid         (snap_valid),
      .snap_ready         (snap_ready),
      .snap               (snap),
      .max_distance       (max_distance_ff),
      .ratio_q8           (ratio_q8_ff),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_match_found    (rsp_match_found),
      .rsp_match_index    (rsp_match_index),
      .rsp_match_distance (rsp_match_distance)
   );

endmodule

// ----- rtl/hrtm_checker.sv -----
// hrtm_checker: port-level assertions on the result channel of the matcher,
// bound to hamming_ratio_test_matcher. Depends on hrtm_pkg.
module hrtm_checker
   import hrtm_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_match_found,
   input logic [INDEX_WIDTH-1:0] rsp_match_index,
   input logic [DIST_WIDTH-1:0]  rsp_match_distance
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_found) &&
      $stable(rsp_match_index) && $stable(rsp_match_distance))
      else $error("result beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_match_found |-> rsp_match_index == '0)
      else $error("index not zero without a match");

   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_match_distance <= DIST_WIDTH'(DESC_WIDTH))
      else $error("distance beyond descriptor length");

endmodule

bind hamming_ratio_test_matcher hrtm_checker u_checker (.*);

// ----- verif/tb_hamming_ratio_test_matcher.sv -----
// tb_hamming_ratio_test_matcher: self-checking bench for the hamming ratio test
// matcher; directed candidate table, then randomised queries under several settings.
// Depends on hrtm_pkg and rtl/hamming_ratio_test_matcher.sv.
module tb_hamming_ratio_test_matcher
   import hrtm_pkg::*;
();

   localparam int MAX_FEATURES = MAX_FEATURES_DEFAULT;
   localparam int ITEM_TARGET  = 750;
   localparam int PHASE_ITEMS  = 90;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD    = 400;
   localparam int CYCLE_LIMIT  = 200000;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE = 8'd7;

   localparam logic [DESC_WIDTH-1:0] ONES = {DESC_WIDTH{1'b1}};
   localparam logic [DESC_WIDTH-1:0] Q_A  = {4{64'h0123_4567_89ab_cdef}};
   localparam logic [DESC_WIDTH-1:0] Q_B  = {4{64'hfedc_ba98_7654_3210}};
   localparam logic [DESC_WIDTH-1:0] Q_C  = {2{128'h5555_aaaa_3333_cccc_0f0f_f0f0_00ff_ff00}};

   typedef struct packed {
      logic                   found;
      logic [INDEX_WIDTH-1:0] index;
      logic [DIST_WIDTH-1:0]  distance;
   } match_type;

   typedef struct packed {
      logic [DESC_WIDTH-1:0]  query;
      logic [DESC_WIDTH-1:0]  cand;
      logic [INDEX_WIDTH-1:0] index;
      logic                   last;
   } cand_beat_type;

   // candidate = query ^ flips, so the distance is the number of flipped bits
   typedef struct packed {
      logic [DESC_WIDTH-1:0]  query;
      logic [DESC_WIDTH-1:0]  flips;
      logic [INDEX_WIDTH-1:0] index;
      logic                   last;
      logic                   known;
      match_type              want;
   } dir_row_type;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   localparam match_type NONE = '{1'b0, 12'd0, 9'd0};

   // rows run under the reset settings: max_distance 50, ratio 230/256
   localparam dir_row_type DIRECTED [0:21] = '{
      '{'0,   '0,                12'd0,    1'b1, 1'b1, '{1'b1, 12'd0,  9'd0}},
      '{ONES, ONES,              12'd4095, 1'b1, 1'b1, '{1'b0, 12'd0,  9'd256}},
      '{Q_A,  ONES >> 246,       12'hfff,  1'b0, 1'b0, NONE},
      '{Q_A,  '0,                12'd5,    1'b1, 1'b1, '{1'b1, 12'd5,  9'd0}},
      '{Q_B,  256'h7,            12'd9,    1'b0, 1'b0, NONE},
      '{Q_B,  256'h7 << 100,     12'd10,   1'b1, 1'b1, '{1'b0, 12'd0,  9'd3}},
      '{Q_C,  ONES >> 206,       12'd77,   1'b1, 1'b1, '{1'b1, 12'd77, 9'd50}},
      '{Q_C,  ONES >> 205,       12'd78,   1'b1, 1'b1, '{1'b0, 12'd0,  9'd51}},
      '{Q_A,  ONES >> 236,       12'd100,  1'b0, 1'b0, NONE},
      '{Q_A,  ONES << 233,       12'd101,  1'b0, 1'b0, NONE},
      '{Q_A,  ONES << 234,       12'd102,  1'b1, 1'b0, NONE},
      '{Q_B,  ONES >> 236,       12'd103,  1'b0, 1'b0, NONE},
      '{Q_B,  ONES << 233,       12'd104,  1'b1, 1'b0, NONE},
      '{Q_C,  ONES >> 226,       12'd1,    1'b0, 1'b0, NONE},
      '{Q_C,  ONES << 246,       12'd2,    1'b0, 1'b0, NONE},
      '{Q_C,  ONES >> 236,       12'd3,    1'b0, 1'b0, NONE},
      '{Q_C,  ONES >> 216,       12'd4,    1'b1, 1'b0, NONE},
      '{Q_A,  ONES >> 251,       12'd200,  1'b0, 1'b0, NONE},
      '{Q_B,  ONES << 248,       12'd201,  1'b1, 1'b0, NONE},
      '{~Q_A, {1'b1, 254'd0, 1'b1}, 12'd300, 1'b1, 1'b0, NONE},
      '{ONES, ONES,              12'd11,   1'b0, 1'b0, NONE},
      '{ONES, '0,                12'd12,   1'b1, 1'b1, '{1'b1, 12'd12, 9'd0}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [WORD_WIDTH-1:0]      req_query_word0 = '0;
   logic [WORD_WIDTH-1:0]      req_query_word1 = '0;
   logic [WORD_WIDTH-1:0]      req_query_word2 = '0;
   logic [WORD_WIDTH-1:0]      req_query_word3 = '0;
   logic [WORD_WIDTH-1:0]      req_cand_word0 = '0;
   logic [WORD_WIDTH-1:0]      req_cand_word1 = '0;
   logic [WORD_WIDTH-1:0]      req_cand_word2 = '0;
   logic [WORD_WIDTH-1:0]      req_cand_word3 = '0;
   logic [INDEX_WIDTH-1:0]     req_cand_index = '0;
   logic                       req_last_cand = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_match_found;
   logic [INDEX_WIDTH-1:0]     rsp_match_index;
   logic [DIST_WIDTH-1:0]      rsp_match_distance;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CFG_WIDTH-1:0]       csr_data = '0;

   hamming_ratio_test_matcher dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_query_word0    (req_query_word0),
      .req_query_word1    (req_query_word1),
      .req_query_word2    (req_query_word2),
      .req_query_word3    (req_query_word3),
      .req_cand_word0     (req_cand_word0),
      .req_cand_word1     (req_cand_word1),
      .req_cand_word2     (req_cand_word2),
      .req_cand_word3     (req_cand_word3),
      .req_cand_index     (req_cand_index),
      .req_last_cand      (req_last_cand),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_match_found    (rsp_match_found),
      .rsp_match_index    (rsp_match_index),
      .rsp_match_distance (rsp_match_distance),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // matcher model: settings and search state
   logic [CFG_WIDTH-1:0]   cfg_max_distance = MAX_DISTANCE_RESET;
   logic [CFG_WIDTH-1:0]   cfg_ratio = RATIO_Q8_RESET;
   logic [DIST_WIDTH-1:0]  best_dist_q = '0;
   logic [DIST_WIDTH-1:0]  second_dist_q = '0;
   logic [INDEX_WIDTH-1:0] best_index_q = '0;
   bit                     best_seen = 1'b0;
   bit                     second_seen = 1'b0;

   match_type expected_matches [$];
   int     error_count = 0;
   int     item_count = 0;
   int     cycle_count = 0;
   int     burst_left = 0;
   bit     steady_flow = 1'b0;
   int     hold_req = 0;
   int     hold_ack = 0;
   int     hold_left = 0;
   int     rx_left = 0;
   rx_mode_type rx_mode = RX_OPEN;

   // updates the search state; returns 1 with the verdict when the query closes
   function automatic bit track_candidate(input cand_beat_type b, output match_type verdict);
      logic [DIST_WIDTH-1:0] cand_dist;
      bit                    found;
      cand_dist = DIST_WIDTH'($countones(b.query ^ b.cand));
      verdict = NONE;
      if (int'(b.index) < MAX_FEATURES) begin
         if (!best_seen || cand_dist < best_dist_q) begin
            second_dist_q = best_dist_q;
            second_seen = best_seen;
            best_dist_q = cand_dist;
            best_seen = 1'b1;
            best_index_q = b.index;
         end else if (!second_seen || cand_dist < second_dist_q) begin
            second_dist_q = cand_dist;
            second_seen = 1'b1;
         end
      end
      if (!b.last) return 1'b0;
      found = best_seen && best_dist_q <= cfg_max_distance && cfg_ratio != 0 &&
              (!second_seen ||
               int'(best_dist_q) * 256 < int'(second_dist_q) * int'(cfg_ratio));
      verdict.found    = found;
      verdict.index    = found ? best_index_q : '0;
      verdict.distance = best_seen ? best_dist_q : '0;
      best_dist_q = '0;
      second_dist_q = '0;
      best_index_q = '0;
      best_seen = 1'b0;
      second_seen = 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [DESC_WIDTH-1:0] rand_desc();
      logic [DESC_WIDTH-1:0] d;
      for (int i = 0; i < DESC_WIDTH / 32; i++) d[32*i +: 32] = $urandom;
      return d;
   endfunction

   function automatic logic [DESC_WIDTH-1:0] flip_bits(input int k);
      logic [DESC_WIDTH-1:0] m;
      m = '0;
      if (k >= DESC_WIDTH) return ONES;
      while ($countones(m) < k) m[$urandom_range(0, DESC_WIDTH - 1)] = 1'b1;
      return m;
   endfunction

   function automatic int clamp_dist(input int d);
      return (d < 0) ? 0 : ((d > DESC_WIDTH) ? DESC_WIDTH : d);
   endfunction

   task automatic send_cand(input cand_beat_type b, input bit use_want,
                            input match_type want);
      int        gap;
      match_type verdict;
      match_type next_m;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
      end
      if (gap > 0 && !steady_flow) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_query_word0 <= b.query[63:0];
      req_query_word1 <= b.query[127:64];
      req_query_word2 <= b.query[191:128];
      req_query_word3 <= b.query[255:192];
      req_cand_word0  <= b.cand[63:0];
      req_cand_word1  <= b.cand[127:64];
      req_cand_word2  <= b.cand[191:128];
      req_cand_word3  <= b.cand[255:192];
      req_cand_index  <= b.index;
      req_last_cand   <= b.last;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      item_count++;
      if (track_candidate(b, verdict)) begin
         next_m = use_want ? want : verdict;
         expected_matches = {expected_matches, next_m};
      end
   endtask

   // leaves csr_valid high so back-to-back writes need no toggle
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CFG_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MAX_DISTANCE: cfg_max_distance = value;
         CSR_RATIO_Q8:     cfg_ratio = value;
         default: ;
      endcase
   endtask

   task automatic set_config(input int max_dist, input int ratio, input bit spare);
      write_csr(CSR_MAX_DISTANCE, CFG_WIDTH'(max_dist));
      write_csr(CSR_RATIO_Q8, CFG_WIDTH'(ratio));
      if (spare) write_csr(CSR_SPARE, CFG_WIDTH'($urandom_range(0, 511)));
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_matches.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // whole queries with distances clustered so best and second sit close together
   task automatic random_queries(input int n_items);
      int            sent;
      int            len;
      int            centre;
      int            pick;
      cand_beat_type b;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
         pick = $urandom_range(0, 9);
         if (pick < 6) centre = $urandom_range(0, 60);
         else if (pick < 8) centre = $urandom_range(0, DESC_WIDTH);
         else centre = clamp_dist(int'(cfg_max_distance) + $urandom_range(0, 8) - 4);
         b.query = rand_desc();
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) b.query = rand_desc();
            if (pick == 1) b.cand = rand_desc();
            else b.cand = b.query ^ flip_bits(clamp_dist(centre + $urandom_range(0, 10)));
            case ($urandom_range(0, 9))
               0:       b.index = '0;
               1:       b.index = '1;
               default: b.index = INDEX_WIDTH'($urandom_range(0, 4095));
            endcase
            b.last = (i == len - 1);
            send_cand(b, 1'b0, NONE);
         end
         sent += len;
      end
   endtask

   // result side: own stall pattern, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_req != hold_ack) begin
         hold_ack = hold_req;
         hold_left = LONG_HOLD;
      end
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(16, 128);
      end else begin
         rx_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_OPEN:   rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:   rsp_ready <= 1'(rx_left / 4 % 2);
         endcase
      end
   end

   always @(posedge clock) begin
      match_type exp_m;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_matches.size() == 0) begin
            $error("result beat with no query outstanding");
            error_count++;
         end else begin
            exp_m = expected_matches.pop_front();
            if (rsp_match_found !== exp_m.found) begin
               $error("match_found: expected %0d, got %0d", exp_m.found, rsp_match_found);
               error_count++;
            end
            if (rsp_match_index !== exp_m.index) begin
               $error("match_index: expected %0d, got %0d", exp_m.index, rsp_match_index);
               error_count++;
            end
            if (rsp_match_distance !== exp_m.distance) begin
               $error("match_distance: expected %0d, got %0d", exp_m.distance,
                      rsp_match_distance);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      cand_beat_type b;
      int            phase;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED[i]) begin
         b.query = DIRECTED[i].query;
         b.cand  = DIRECTED[i].query ^ DIRECTED[i].flips;
         b.index = DIRECTED[i].index;
         b.last  = DIRECTED[i].last;
         send_cand(b, DIRECTED[i].known, DIRECTED[i].want);
      end
      drain();
      phase = 0;
      while (item_count < ITEM_TARGET) begin
         case (phase)
            0:       set_config(0, 0, 1'b1);
            1:       set_config(256, 256, 1'b0);
            2:       set_config(0, 256, 1'b0);
            3:       set_config(256, 0, 1'b0);
            4:       set_config(50, 230, 1'b0);
            default: set_config($urandom_range(0, 256), $urandom_range(0, 256), 1'b0);
         endcase
         // fill the pipe against a stalled result side
         if (phase == 1) begin
            hold_req++;
            steady_flow = 1'b1;
         end
         random_queries(PHASE_ITEMS);
         steady_flow = 1'b0;
         drain();
         phase++;
      end
      if (error_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/hrtm_pkg.sv
rtl/hrtm_distance.sv
rtl/hrtm_tracker.sv
rtl/hrtm_decide.sv
rtl/hamming_ratio_test_matcher.sv
rtl/hrtm_checker.sv
verif/tb_hamming_ratio_test_matcher.sv
